// ===== design/foc_pkg.sv =====
// ----------------------------------------------------------------------------
// foc_pkg
// Shared constants for the overlap-save FFT channelizer.
// ----------------------------------------------------------------------------
package foc_pkg;

   localparam int POINTS_DEF        = 64;
   localparam int DECIMATION_DEF    = 4;
   localparam int OVERLAP_PARTS_DEF = 4;

   localparam int SAMPLE_W = 16;   // Q1.15 sample component
   localparam int TW_W     = 17;   // twiddle component, +32768 must fit

   // pi/2 in Q30, seed of the sine table series
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

endpackage

// ===== design/foc_req_if.sv =====
// ----------------------------------------------------------------------------
// foc_req_if
// Input sample channel: one complex Q1.15 sample per item.
// ----------------------------------------------------------------------------
interface foc_req_if import foc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

// ===== design/foc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// foc_rsp_if
// Result channel: one channel sample per item.
// ----------------------------------------------------------------------------
interface foc_rsp_if import foc_pkg::*; #(parameter int CHW = 3) ();
   logic                       valid;
   logic                       ready;
   logic [CHW-1:0]             channel;
   logic signed [SAMPLE_W-1:0] out_re;
   logic signed [SAMPLE_W-1:0] out_im;
   logic                       last_of_block;

   modport source (output valid, output channel, output out_re, output out_im,
                   output last_of_block, input ready);
   modport sink   (input valid, input channel, input out_re, input out_im,
                   input last_of_block, output ready);
endinterface

// ===== design/fft_overlap_channelizer.sv =====
// ----------------------------------------------------------------------------
// fft_overlap_channelizer
// Overlap-save FFT channelizer: forward FFT over a sliding window, then one
// small inverse FFT per output channel.
// ----------------------------------------------------------------------------
// req_chan takes one complex Q1.15 sample per item. Every HOP = POINTS -
// POINTS/OVERLAP_PARTS samples complete a window; the block then stops
// taking samples and computes the frame. rsp_chan gives, channel by channel,
// outputs M/OVERLAP_PARTS..M-1 of each inverse FFT (M = POINTS/DECIMATION),
// last_of_block marking the final item of the frame.
// All state sits in two RAMs: a circular sample window and a work RAM that
// holds the spectrum and one channel buffer. One butterfly unit does all
// FFT work, each butterfly taking the steps read a, read b, multiply, write a,
// write b. The frame simply waits on rsp ready while the receiver stalls.
// After reset a clearing pass zeroes the window before the first sample is
// taken.
// ----------------------------------------------------------------------------
module fft_overlap_channelizer import foc_pkg::*; #(
   parameter int POINTS        = POINTS_DEF,
   parameter int DECIMATION    = DECIMATION_DEF,
   parameter int OVERLAP_PARTS = OVERLAP_PARTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   foc_req_if.sink    req_chan,
   foc_rsp_if.source  rsp_chan
);
   localparam int N        = POINTS;
   localparam int LOGN     = $clog2(N);
   localparam int M        = N / DECIMATION;
   localparam int LOGM     = $clog2(M);
   localparam int KEEP     = N / OVERLAP_PARTS;
   localparam int HOP      = N - KEEP;
   localparam int CH_STEP  = (N - M) / DECIMATION;
   localparam int OUT_SKIP = M / OVERLAP_PARTS;
   localparam int CW       = 17 + LOGM;
   localparam int CHW      = $clog2(DECIMATION + 1);
   localparam int AW       = LOGN + 1;
   localparam int SW       = $clog2(LOGN);

   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_BF_RA  = 4'd3;
   localparam logic [3:0] ST_BF_RB  = 4'd4;
   localparam logic [3:0] ST_BF_MUL = 4'd5;
   localparam logic [3:0] ST_BF_WA  = 4'd6;
   localparam logic [3:0] ST_BF_WB  = 4'd7;
   localparam logic [3:0] ST_GATH   = 4'd8;
   localparam logic [3:0] ST_OUT_RD = 4'd9;
   localparam logic [3:0] ST_OUT_LD = 4'd10;
   localparam logic [3:0] ST_OUT_WT = 4'd11;

   localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
   localparam logic signed [CW-1:0] SAT_LO = CW'(-32768);

   logic [3:0]      state_ff, state_in;
   logic [LOGN-1:0] cnt_ff, cnt_in, base_ff, base_in, chbase_ff, chbase_in;
   logic [LOGN:0]   idx_ff, idx_in;
   logic [LOGN-2:0] j_ff, j_in;
   logic [SW-1:0]   stg_ff, stg_in;
   logic            inv_ff, inv_in, pend_ff, pend_in;
   logic [AW-1:0]   pdst_ff, pdst_in;
   logic [CHW-1:0]  ch_ff, ch_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic signed [CW-1:0]       are_ff, aim_ff;
   logic [CHW-1:0]             rsp_ch_ff;
   logic signed [SAMPLE_W-1:0] rsp_re_ff, rsp_im_ff;
   logic                       rsp_last_ff;

   // window RAM
   logic                win_we;
   logic [LOGN-1:0]     win_waddr, win_raddr;
   logic [2*SAMPLE_W-1:0] win_wdata, win_rdata;

   // work RAM: spectrum in the lower half, channel buffer in the upper half
   logic                work_we;
   logic [AW-1:0]       work_waddr, work_raddr;
   logic [2*CW-1:0]     work_wdata, work_rdata;
   logic signed [CW-1:0] wk_re, wk_im;

   logic [LOGN-1:0]     jx, half, kk, addr_a, addr_b, gsrc, rev_n;
   logic [LOGM-1:0]     rev_m;
   logic [2*LOGN-2:0]   twx;
   logic [LOGN-2:0]     tw_idx;
   logic signed [TW_W-1:0] tw_cos, tw_sin;
   logic signed [CW-1:0] x_re, x_im, y_re, y_im;
   logic [LOGN-2:0]     j_last;
   logic [SW-1:0]       stg_last;
   logic                req_fire;

   assign wk_re = work_rdata[2*CW-1:CW];
   assign wk_im = work_rdata[CW-1:0];

   foc_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(N)) u_win_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (win_waddr),
      .wdata (win_wdata),
      .raddr (win_raddr),
      .rdata (win_rdata)
   );

   foc_ram #(.WIDTH(2*CW), .DEPTH(2*N)) u_work_ram (
      .clock (clock),
      .we    (work_we),
      .waddr (work_waddr),
      .wdata (work_wdata),
      .raddr (work_raddr),
      .rdata (work_rdata)
   );

   foc_twiddle #(.POINTS(N)) u_twiddle (
      .tw_idx (tw_idx),
      .tw_cos (tw_cos),
      .tw_sin (tw_sin)
   );

   foc_bfly #(.CW(CW)) u_bfly (
      .clock   (clock),
      .load    (state_ff == ST_BF_MUL),
      .inverse (inv_ff),
      .a_re    (are_ff),
      .a_im    (aim_ff),
      .b_re    (wk_re),
      .b_im    (wk_im),
      .tw_cos  (tw_cos),
      .tw_sin  (tw_sin),
      .x_re    (x_re),
      .x_im    (x_im),
      .y_re    (y_re),
      .y_im    (y_im)
   );

   // butterfly addressing for stage stg_ff, butterfly j_ff
   always_comb begin
      jx     = LOGN'(j_ff);
      half   = LOGN'(1) << stg_ff;
      kk     = jx & (half - LOGN'(1));
      addr_a = (((jx >> stg_ff) << stg_ff) << 1) | kk;
      addr_b = addr_a | half;
      twx    = ({(LOGN-1)'(0), kk} << (LOGN-1)) >> stg_ff;
      tw_idx = twx[LOGN-2:0];
      gsrc   = chbase_ff + LOGN'(N/2) + (idx_ff[LOGN-1:0] ^ LOGN'(M/2));
      for (int b = 0; b < LOGN; b++) begin
         rev_n[b] = idx_ff[LOGN-1-b];
      end
      for (int b = 0; b < LOGM; b++) begin
         rev_m[b] = idx_ff[LOGM-1-b];
      end
      j_last   = inv_ff ? (LOGN-1)'(M/2 - 1) : (LOGN-1)'(N/2 - 1);
      stg_last = inv_ff ? SW'(LOGM - 1) : SW'(LOGN - 1);
   end

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // window RAM ports
   always_comb begin
      win_we    = 1'b0;
      win_waddr = base_ff + LOGN'(KEEP) + cnt_ff;
      win_wdata = {req_chan.sample_re, req_chan.sample_im};
      win_raddr = base_ff + idx_ff[LOGN-1:0];
      if (state_ff == ST_CLR) begin
         win_we    = 1'b1;
         win_waddr = idx_ff[LOGN-1:0];
         win_wdata = '0;
      end else if (req_fire) begin
         win_we = 1'b1;
      end
   end

   // work RAM ports
   always_comb begin
      work_we    = 1'b0;
      work_waddr = pdst_ff;
      work_wdata = work_rdata;
      case (state_ff)
         ST_BF_RA: work_raddr = {inv_ff, addr_a};
         ST_BF_RB: work_raddr = {inv_ff, addr_b};
         ST_GATH:  work_raddr = {1'b0, gsrc};
         ST_OUT_RD: work_raddr = {1'b1, idx_ff[LOGN-1:0]};
         default:  work_raddr = {inv_ff, addr_a};
      endcase
      if (pend_ff) begin
         work_we = 1'b1;
         if (state_ff == ST_LOAD) begin
            work_wdata = {CW'($signed(win_rdata[2*SAMPLE_W-1:SAMPLE_W])),
                          CW'($signed(win_rdata[SAMPLE_W-1:0]))};
         end
      end else if (state_ff == ST_BF_WA) begin
         work_we    = 1'b1;
         work_waddr = {inv_ff, addr_a};
         work_wdata = {x_re, x_im};
      end else if (state_ff == ST_BF_WB) begin
         work_we    = 1'b1;
         work_waddr = {inv_ff, addr_b};
         work_wdata = {y_re, y_im};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      chbase_in    = chbase_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      stg_in       = stg_ff;
      inv_in       = inv_ff;
      pend_in      = 1'b0;
      pdst_in      = pdst_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_CLR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (LOGN+1)'(N - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LOGN'(HOP - 1)) begin
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // window entry idx goes to its bit-reversed spectrum slot
            if (idx_ff == (LOGN+1)'(N)) begin
               base_in  = base_ff + LOGN'(HOP);
               inv_in   = 1'b0;
               stg_in   = '0;
               j_in     = '0;
               state_in = ST_BF_RA;
            end else begin
               pend_in = 1'b1;
               pdst_in = {1'b0, rev_n};
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_BF_RA:  state_in = ST_BF_RB;
         ST_BF_RB:  state_in = ST_BF_MUL;
         ST_BF_MUL: state_in = ST_BF_WA;
         ST_BF_WA:  state_in = ST_BF_WB;
         ST_BF_WB: begin
            state_in = ST_BF_RA;
            j_in     = j_ff + 1'b1;
            if (j_ff == j_last) begin
               j_in   = '0;
               stg_in = stg_ff + 1'b1;
               if (stg_ff == stg_last) begin
                  stg_in = '0;
                  if (inv_ff) begin
                     idx_in   = (LOGN+1)'(OUT_SKIP);
                     state_in = ST_OUT_RD;
                  end else begin
                     ch_in     = '0;
                     chbase_in = '0;
                     idx_in    = '0;
                     state_in  = ST_GATH;
                  end
               end
            end
         end
         ST_GATH: begin
            if (idx_ff == (LOGN+1)'(M)) begin
               inv_in   = 1'b1;
               stg_in   = '0;
               j_in     = '0;
               state_in = ST_BF_RA;
            end else begin
               pend_in = 1'b1;
               pdst_in = {1'b1, LOGN'(rev_m)};
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_WT;
         end
         ST_OUT_WT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == (LOGN+1)'(M - 1)) begin
                  if (ch_ff == CHW'(DECIMATION)) begin
                     state_in = ST_IDLE;
                  end else begin
                     ch_in     = ch_ff + 1'b1;
                     chbase_in = chbase_ff + LOGN'(CH_STEP);
                     idx_in    = '0;
                     state_in  = ST_GATH;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         base_ff      <= '0;
         chbase_ff    <= '0;
         idx_ff       <= '0;
         j_ff         <= '0;
         stg_ff       <= '0;
         inv_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         pdst_ff      <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         chbase_ff    <= chbase_in;
         idx_ff       <= idx_in;
         j_ff         <= j_in;
         stg_ff       <= stg_in;
         inv_ff       <= inv_in;
         pend_ff      <= pend_in;
         pdst_ff      <= pdst_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_BF_RB) begin
         are_ff <= wk_re;
         aim_ff <= wk_im;
      end
      if (state_ff == ST_OUT_LD) begin
         rsp_ch_ff   <= ch_ff;
         rsp_re_ff   <= (wk_re > SAT_HI) ? SAMPLE_W'(32767) :
                        (wk_re < SAT_LO) ? SAMPLE_W'(-32768) : SAMPLE_W'(wk_re);
         rsp_im_ff   <= (wk_im > SAT_HI) ? SAMPLE_W'(32767) :
                        (wk_im < SAT_LO) ? SAMPLE_W'(-32768) : SAMPLE_W'(wk_im);
         rsp_last_ff <= (ch_ff == CHW'(DECIMATION)) && (idx_ff == (LOGN+1)'(M - 1));
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.channel       = rsp_ch_ff;
   assign rsp_chan.out_re        = rsp_re_ff;
   assign rsp_chan.out_im        = rsp_im_ff;
   assign rsp_chan.last_of_block = rsp_last_ff;

endmodule

// ===== design/foc_ram.sv =====
// ----------------------------------------------------------------------------
// foc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module foc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// ===== design/foc_twiddle.sv =====
// ----------------------------------------------------------------------------
// foc_twiddle
// Twiddle lookup: cos and sin of 2*pi*k/POINTS from a quarter-wave table
// that is computed at elaboration with a Q30 Taylor series.
// ----------------------------------------------------------------------------
module foc_twiddle import foc_pkg::*; #(
   parameter int POINTS = POINTS_DEF
) (
   input  logic [$clog2(POINTS)-2:0] tw_idx,
   output logic signed [TW_W-1:0]    tw_cos,
   output logic signed [TW_W-1:0]    tw_sin
);
   localparam int LOGN = $clog2(POINTS);
   localparam int QTAB = POINTS / 4;

   logic signed [TW_W-1:0] qtab [QTAB+1];

   for (genvar j = 0; j <= QTAB; j++) begin : g_qsine
      localparam logic [63:0] X   = PI_HALF_Q30 * 64'(j) / QTAB;
      localparam logic [63:0] X2  = (X * X) >> 30;
      localparam logic [63:0] T1  = ((X   * X2) >> 30) / 6;
      localparam logic [63:0] T2  = ((T1  * X2) >> 30) / 20;
      localparam logic [63:0] T3  = ((T2  * X2) >> 30) / 42;
      localparam logic [63:0] T4  = ((T3  * X2) >> 30) / 72;
      localparam logic [63:0] T5  = ((T4  * X2) >> 30) / 110;
      localparam logic [63:0] T6  = ((T5  * X2) >> 30) / 156;
      localparam logic [63:0] T7  = ((T6  * X2) >> 30) / 210;
      localparam logic [63:0] T8  = ((T7  * X2) >> 30) / 272;
      localparam logic [63:0] T9  = ((T8  * X2) >> 30) / 342;
      localparam logic [63:0] T10 = ((T9  * X2) >> 30) / 420;
      localparam logic [63:0] T11 = ((T10 * X2) >> 30) / 506;
      localparam logic [63:0] T12 = ((T11 * X2) >> 30) / 600;
      localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
                                    - T9 + T10 - T11 + T12;
      localparam logic [63:0] Q   = (SUM + 64'd16384) >> 15;
      assign qtab[j] = TW_W'(Q);
   end

   always_comb begin
      if (tw_idx <= (LOGN-1)'(QTAB)) begin
         tw_cos = qtab[(LOGN-1)'(QTAB) - tw_idx];
         tw_sin = qtab[tw_idx];
      end else begin
         tw_cos = -qtab[tw_idx - (LOGN-1)'(QTAB)];
         tw_sin = qtab[(LOGN-1)'(2 * QTAB) - tw_idx];
      end
   end
endmodule

// ===== design/foc_bfly.sv =====
// ----------------------------------------------------------------------------
// foc_bfly
// Radix-2 butterfly, two stages. Forward halves the outputs with rounding,
// inverse uses the conjugate twiddle and no scaling.
// ----------------------------------------------------------------------------
module foc_bfly import foc_pkg::*; #(
   parameter int CW = 21
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   inverse,
   input  logic signed [CW-1:0]   a_re,
   input  logic signed [CW-1:0]   a_im,
   input  logic signed [CW-1:0]   b_re,
   input  logic signed [CW-1:0]   b_im,
   input  logic signed [TW_W-1:0] tw_cos,
   input  logic signed [TW_W-1:0] tw_sin,
   output logic signed [CW-1:0]   x_re,
   output logic signed [CW-1:0]   x_im,
   output logic signed [CW-1:0]   y_re,
   output logic signed [CW-1:0]   y_im
);
   localparam int PW = CW + TW_W + 1;

   logic signed [PW-1:0]   br, bi, wc, ws, pr, pi;
   logic signed [CW+1:0]   tr_in, ti_in, tr_ff, ti_ff;
   logic signed [CW-1:0]   ar_ff, ai_ff;
   logic                   inv_ff;
   logic signed [CW+2:0]   sum_re, sum_im, dif_re, dif_im;

   assign br = PW'(b_re);
   assign bi = PW'(b_im);
   assign wc = PW'(tw_cos);
   assign ws = PW'(tw_sin);

   always_comb begin
      if (inverse) begin
         pr = br * wc - bi * ws + PW'(16384);
         pi = bi * wc + br * ws + PW'(16384);
      end else begin
         pr = br * wc + bi * ws + PW'(16384);
         pi = bi * wc - br * ws + PW'(16384);
      end
      tr_in = (CW+2)'(pr >>> 15);
      ti_in = (CW+2)'(pi >>> 15);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tr_ff  <= tr_in;
         ti_ff  <= ti_in;
         ar_ff  <= a_re;
         ai_ff  <= a_im;
         inv_ff <= inverse;
      end
   end

   always_comb begin
      sum_re = (CW+3)'(ar_ff) + (CW+3)'(tr_ff);
      sum_im = (CW+3)'(ai_ff) + (CW+3)'(ti_ff);
      dif_re = (CW+3)'(ar_ff) - (CW+3)'(tr_ff);
      dif_im = (CW+3)'(ai_ff) - (CW+3)'(ti_ff);
      if (inv_ff) begin
         x_re = CW'(sum_re);
         x_im = CW'(sum_im);
         y_re = CW'(dif_re);
         y_im = CW'(dif_im);
      end else begin
         x_re = CW'((sum_re + (CW+3)'(1)) >>> 1);
         x_im = CW'((sum_im + (CW+3)'(1)) >>> 1);
         y_re = CW'((dif_re + (CW+3)'(1)) >>> 1);
         y_im = CW'((dif_im + (CW+3)'(1)) >>> 1);
      end
   end
endmodule

// ===== tb/tb_if.sv =====
// ----------------------------------------------------------------------------
// tb_if
// Harness note: the channel interfaces come from the design folder; this file
// carries the shared result record used by the bench.
// ----------------------------------------------------------------------------
package tb_pkg;
   import foc_pkg::*;

   typedef struct packed {
      logic [2:0]                 channel;
      logic signed [SAMPLE_W-1:0] out_re;
      logic signed [SAMPLE_W-1:0] out_im;
      logic                       last_of_block;
   } chan_sample_type;
endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Bench for the overlap-save FFT channelizer: directed and random samples go
// in with bursty valid, results drain with a stalling ready, and every item
// is checked against a fixed-point channelizer model kept in the bench.
// ----------------------------------------------------------------------------
module tb import foc_pkg::*, tb_pkg::*; ;

   localparam int N     = POINTS_DEF;
   localparam int DEC   = DECIMATION_DEF;
   localparam int M     = N / DEC;
   localparam int KEEP  = N / OVERLAP_PARTS_DEF;
   localparam int HOP   = N - KEEP;
   localparam int STEP  = (N - M) / DEC;
   localparam int SKIP  = M / OVERLAP_PARTS_DEF;
   localparam int QT    = N / 4;
   localparam int NRAND = 150;
   localparam int NDIR  = 20;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;

   foc_req_if req_chan ();
   foc_rsp_if rsp_chan ();

   fft_overlap_channelizer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // model state
   longint       qsine [QT+1];
   logic signed [31:0] win_re [N], win_im [N];
   int           fill_cnt;
   chan_sample_type expected_q [$];

   int  errors = 0;
   int  frames = 0;
   int  results_seen = 0;
   int  sent = 0;
   bit  done_sending = 0;
   bit  long_stall = 0;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   task automatic build_sine();
      longint unsigned x, x2, term, sum;
      for (int j = 0; j <= QT; j++) begin
         x = longint'(PI_HALF_Q30) * j / QT;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n & 1) sum -= term;
            else sum += term;
         end
         qsine[j] = longint'((sum + (1 << 14)) >> 15);
      end
   endtask

   task automatic tw(input int k, output longint c, output longint s);
      k = k & (N / 2 - 1);
      if (k <= QT) begin
         c = qsine[QT-k];
         s = qsine[k];
      end else begin
         c = -qsine[k-QT];
         s = qsine[2*QT-k];
      end
   endtask

   task automatic run_fft(ref longint re[], ref longint im[], input int n,
                          input bit inv);
      int j, bitv, half, stride, a, b;
      longint t, c, s, br, bi, tr, ti, ar, ai;
      j = 0;
      for (int i = 1; i < n; i++) begin
         bitv = n >> 1;
         while (j & bitv) begin
            j ^= bitv;
            bitv >>= 1;
         end
         j |= bitv;
         if (i < j) begin
            t = re[i]; re[i] = re[j]; re[j] = t;
            t = im[i]; im[i] = im[j]; im[j] = t;
         end
      end
      for (int len = 2; len <= n; len <<= 1) begin
         half = len >> 1;
         stride = N / len;
         for (int base = 0; base < n; base += len) begin
            for (int k = 0; k < half; k++) begin
               a = base + k;
               b = a + half;
               tw(k * stride, c, s);
               br = re[b]; bi = im[b];
               if (inv) begin
                  tr = fshift(br * c - bi * s + (1 << 14), 15);
                  ti = fshift(bi * c + br * s + (1 << 14), 15);
               end else begin
                  tr = fshift(br * c + bi * s + (1 << 14), 15);
                  ti = fshift(bi * c - br * s + (1 << 14), 15);
               end
               ar = re[a]; ai = im[a];
               if (inv) begin
                  re[a] = ar + tr; im[a] = ai + ti;
                  re[b] = ar - tr; im[b] = ai - ti;
               end else begin
                  re[a] = fshift(ar + tr + 1, 1); im[a] = fshift(ai + ti + 1, 1);
                  re[b] = fshift(ar - tr + 1, 1); im[b] = fshift(ai - ti + 1, 1);
               end
            end
         end
      end
   endtask

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // Push one sample into the window; on a full hop compute the frame.
   task automatic channelize_sample(input logic signed [15:0] re_in,
                                    input logic signed [15:0] im_in);
      longint sre[], sim[], cre[], cim[];
      int p, q, pos, neg;
      chan_sample_type r;
      win_re[KEEP+fill_cnt] = re_in;
      win_im[KEEP+fill_cnt] = im_in;
      fill_cnt++;
      if (fill_cnt < HOP) return;
      sre = new[N];
      sim = new[N];
      cre = new[M];
      cim = new[M];
      for (int i = 0; i < N; i++) begin
         sre[i] = win_re[i];
         sim[i] = win_im[i];
      end
      run_fft(sre, sim, N, 0);
      for (int ch = 0; ch <= DEC; ch++) begin
         pos = ch * STEP + M / 2 + N / 2;
         neg = ch * STEP + N / 2;
         for (int i = 0; i < M / 2; i++) begin
            p = (pos + i) & (N - 1);
            q = (neg + i) & (N - 1);
            cre[i] = sre[p]; cim[i] = sim[p];
            cre[M/2+i] = sre[q]; cim[M/2+i] = sim[q];
         end
         run_fft(cre, cim, M, 1);
         for (int i = SKIP; i < M; i++) begin
            r.channel = ch[2:0];
            r.out_re = sat16(cre[i]);
            r.out_im = sat16(cim[i]);
            r.last_of_block = (ch == DEC && i == M - 1);
            expected_q.push_back(r);
         end
      end
      for (int i = 0; i < KEEP; i++) begin
         win_re[i] = win_re[HOP+i];
         win_im[i] = win_im[HOP+i];
      end
      fill_cnt = 0;
      frames++;
   endtask

   // directed rows: extremes, zeros, alternating bits
   logic signed [15:0] dir_re [NDIR] = '{
      16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh5555, -16'sh5556, 16'sh0001,
      -16'sh0001, 16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh7FFF,
      -16'sh8000, -16'sh8000, 16'sh1234, 16'sh4000, -16'sh4000, 16'sh7FFF,
      16'sh0000, -16'sh8000};
   logic signed [15:0] dir_im [NDIR] = '{
      16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh5556, 16'sh5555, -16'sh0001,
      16'sh0001, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000,
      -16'sh8000, 16'sh7FFF, -16'sh1235, 16'sh0000, 16'sh4000, 16'sh0000,
      -16'sh8000, 16'sh7FFF};

   function automatic logic signed [15:0] rand_comp(int mode);
      case (mode)
         0: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
         1: return $signed(16'($urandom_range(0, 511)) - 16'd256);
         default: return 16'($urandom);
      endcase
   endfunction

   // sender: bursts with gaps
   initial begin
      int total, burst;
      logic signed [15:0] nre, nim;
      total = NDIR + NRAND;
      req_chan.valid <= 0;
      req_chan.sample_re <= '0;
      req_chan.sample_im <= '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      burst = $urandom_range(1, 20);
      while (sent < total) begin
         if (sent < NDIR) begin
            nre = dir_re[sent];
            nim = dir_im[sent];
         end else begin
            nre = rand_comp($urandom_range(0, 3));
            nim = rand_comp($urandom_range(0, 3));
         end
         req_chan.valid <= 1;
         req_chan.sample_re <= nre;
         req_chan.sample_im <= nim;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         channelize_sample(nre, nim);
         sent++;
         burst--;
         if (burst == 0 && sent < total) begin
            req_chan.valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst = $urandom_range(1, 20);
         end
      end
      req_chan.valid <= 0;
      done_sending = 1;
   end

   // receiver: stall pattern, one long hold-off during the third frame
   initial begin
      int phase;
      phase = 0;
      rsp_chan.ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         phase++;
         if (!long_stall && frames >= 2 && sent > 100) begin
            long_stall = 1;
            rsp_chan.ready <= 0;
            repeat (3000) @(posedge clock);
         end
         if (phase % 400 < 150) rsp_chan.ready <= 1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      chan_sample_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: ch %0d re %0d im %0d",
                   rsp_chan.channel, rsp_chan.out_re, rsp_chan.out_im);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_chan.channel !== e.channel) begin
               $error("channel: expected %0d actual %0d", e.channel, rsp_chan.channel);
               errors++;
            end
            if (rsp_chan.out_re !== e.out_re) begin
               $error("out_re: expected %0d actual %0d", e.out_re, rsp_chan.out_re);
               errors++;
            end
            if (rsp_chan.out_im !== e.out_im) begin
               $error("out_im: expected %0d actual %0d", e.out_im, rsp_chan.out_im);
               errors++;
            end
            if (rsp_chan.last_of_block !== e.last_of_block) begin
               $error("last_of_block: expected %0d actual %0d", e.last_of_block,
                      rsp_chan.last_of_block);
               errors++;
            end
         end
      end
   end

   // end of run and idle watchdog
   initial begin
      int idle;
      build_sine();
      for (int i = 0; i < N; i++) begin
         win_re[i] = 0;
         win_im[i] = 0;
      end
      fill_cnt = 0;
      idle = 0;
      @(negedge reset);
      while (!(done_sending && expected_q.size() == 0) && idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      if (idle >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         repeat (3000) @(posedge clock);
         $display("Run covered %0d samples, %0d frames, %0d channel results checked.",
                  sent, frames, results_seen);
         if (errors == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("*** FAILED ***");
         end
         $finish;
      end
   end

endmodule
